// ===== rtl/core/gce_pkg.sv =====
// ----------------------------------------------------------------------------
// gce_pkg
// Shared constants, codes and types of the genotype compact encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gce_pkg;

	// number format and record limits
	localparam int FRACTION_BITS = 28;
	localparam int MAX_SAMPLES   = 1048576;

	// field widths
	localparam int DATA_W     = 32;
	localparam int SCALE_W    = 16;
	localparam int TOL_W      = 29;
	localparam int COUNT_W    = 21;
	localparam int WORD_W     = 16;
	localparam int REGION_W   = 2;
	localparam int POS_W      = 22;
	localparam int BYTES_W    = 24;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;

	// internal widths
	localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
	localparam int EXTRA_W = 22;
	localparam int LIM_W   = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
	localparam int VAL_W   = FRACTION_BITS + 2;
	localparam int ERR_W   = DATA_W + 4;
	localparam int MAG_W   = ERR_W - 1;
	localparam int PROD_W  = VAL_W + SCALE_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// fixed point one and two in the error datapath width
	localparam logic signed [ERR_W-1:0] ONE_E = ERR_W'(1) << FRACTION_BITS;
	localparam logic signed [ERR_W-1:0] TWO_E = ERR_W'(2) << FRACTION_BITS;

	// round to nearest, exact ties down
	localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'((64'(1) << (FRACTION_BITS - 1)) - 1);
	localparam logic [WORD_W-1:0] WORD_MAX         = 16'hFFFF;
	localparam logic [WORD_W-1:0] WORD_ALL_MISSING = 16'hFFFF;
	localparam logic [WORD_W-1:0] WORD_EXTRA_FLAG  = 16'h8000;
	localparam logic [WORD_W-1:0] WORD_ZERO        = 16'h0000;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST        = 16'd10000;
	localparam logic [TOL_W-1:0]   CHECK_TOL_RST    = 29'd2684355;
	localparam logic [TOL_W-1:0]   WRITE_TOL_RST    = 29'd268;
	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 21'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE        = 2'd0,
		REG_CHECK_TOL    = 2'd1,
		REG_WRITE_TOL    = 2'd2,
		REG_SAMPLE_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK           = 3'd0,
		STAT_RANGE        = 3'd1,
		STAT_INCONSISTENT = 3'd2,
		STAT_PART_MISSING = 3'd3,
		STAT_COUNT        = 3'd4
	} status_t;

	typedef enum logic [REGION_W-1:0] {
		REGION_PRIMARY = 2'd0,
		REGION_EXTRA   = 2'd1,
		REGION_LENGTH  = 2'd2
	} region_t;

	// what the primary word of a sample is
	typedef enum logic [1:0] {
		PRIM_SKIP    = 2'd0,
		PRIM_MISSING = 2'd1,
		PRIM_ERROR   = 2'd2,
		PRIM_VALUE   = 2'd3
	} prim_kind_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [TOL_W-1:0]   check_tol;
		logic [TOL_W-1:0]   write_tol;
		logic [COUNT_W-1:0] sample_count;
	} cfg_t;

	// one classified sample, handed from front to back
	typedef struct packed {
		prim_kind_t         prim;
		status_t            status;
		logic [1:0]         n_extra;
		logic [IDX_W-1:0]   pos;
		logic [EXTRA_W-1:0] extra_base;
		logic [VAL_W-1:0]   d;
		logic [VAL_W-1:0]   p0;
		logic [VAL_W-1:0]   p1;
		logic [VAL_W-1:0]   p2;
		logic               report;
		status_t            report_status;
		logic [BYTES_W-1:0] bytes;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/core/gce_sample_if.sv =====
// ----------------------------------------------------------------------------
// gce_sample_if
// Input channel: one sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gce_sample_if import gce_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] dosage;
	logic signed [DATA_W-1:0] prob_zero;
	logic signed [DATA_W-1:0] prob_one;
	logic signed [DATA_W-1:0] prob_two;
	logic                     dosage_missing;
	logic                     zero_missing;
	logic                     one_missing;
	logic                     two_missing;
	logic                     final_sample;

	modport source (
		output valid, dosage, prob_zero, prob_one, prob_two,
		output dosage_missing, zero_missing, one_missing, two_missing, final_sample,
		input  ready
	);
	modport sink (
		input  valid, dosage, prob_zero, prob_one, prob_two,
		input  dosage_missing, zero_missing, one_missing, two_missing, final_sample,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/gce_result_if.sv =====
// ----------------------------------------------------------------------------
// gce_result_if
// Output channel: one encoded word or length report per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gce_result_if import gce_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   word;
	logic [REGION_W-1:0] region;
	logic [POS_W-1:0]    position;
	logic [BYTES_W-1:0]  record_bytes;
	logic [STATUS_W-1:0] status;
	logic                run_end;

	modport source (
		output valid, word, region, position, record_bytes, status, run_end,
		input  ready
	);
	modport sink (
		input  valid, word, region, position, record_bytes, status, run_end,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/gce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gce_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface gce_cfg_if import gce_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gce_front.sv =====
// ----------------------------------------------------------------------------
// gce_front
// Accepts samples, checks range and consistency, keeps record state and
// hands one job per sample that has results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gce_front import gce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gce_sample_if.sink sample,
	input  cfg_t       cfg,
	input  logic       full,
	output logic       push,
	output job_t       push_job
);

	// stage 1: registered sample with range flags and error magnitudes
	logic               valid_s1;
	logic [VAL_W-1:0]   d_s1, p0_s1, p1_s1, p2_s1;
	logic               range_bad_s1;
	logic               all_miss_s1, any_miss_s1, final_s1;
	logic [MAG_W-1:0]   e1_s1, e2_s1;

	// record state
	logic [IDX_W-1:0]   idx_q;
	logic [EXTRA_W-1:0] extra_q;
	logic               failed_q;

	logic signed [ERR_W-1:0] d_x, p0_x, p1_x, p2_x, e1_raw, e2_raw;
	logic [MAG_W-1:0]   e1_abs, e2_abs;
	logic               range_bad;
	logic               adv, load;

	logic [LIM_W-1:0]   cnt_w, max_w, limit, idx_w;
	logic               too_many, mismatch, has_job;
	prim_kind_t         prim;
	status_t            stat;
	logic [1:0]         n_extra;
	logic               failed_next;
	logic [IDX_W-1:0]   idx_next;
	logic [EXTRA_W-1:0] extra_next;
	logic [EXTRA_W:0]   total;

	always_comb begin
		d_x  = {{(ERR_W-DATA_W){sample.dosage[DATA_W-1]}}, sample.dosage};
		p0_x = {{(ERR_W-DATA_W){sample.prob_zero[DATA_W-1]}}, sample.prob_zero};
		p1_x = {{(ERR_W-DATA_W){sample.prob_one[DATA_W-1]}}, sample.prob_one};
		p2_x = {{(ERR_W-DATA_W){sample.prob_two[DATA_W-1]}}, sample.prob_two};
		e1_raw = ONE_E - p0_x - p1_x - p2_x;
		e2_raw = d_x - p1_x - (p2_x <<< 1);
		e1_abs = e1_raw[ERR_W-1] ? MAG_W'(-e1_raw) : MAG_W'(e1_raw);
		e2_abs = e2_raw[ERR_W-1] ? MAG_W'(-e2_raw) : MAG_W'(e2_raw);
		range_bad = d_x[ERR_W-1] || (d_x > TWO_E)
			|| p0_x[ERR_W-1] || (p0_x > ONE_E)
			|| p1_x[ERR_W-1] || (p1_x > ONE_E)
			|| p2_x[ERR_W-1] || (p2_x > ONE_E);
	end

	assign adv          = valid_s1 && !full;
	assign sample.ready = !valid_s1 || adv;
	assign load         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_s1         <= sample.dosage[VAL_W-1:0];
			p0_s1        <= sample.prob_zero[VAL_W-1:0];
			p1_s1        <= sample.prob_one[VAL_W-1:0];
			p2_s1        <= sample.prob_two[VAL_W-1:0];
			range_bad_s1 <= range_bad;
			all_miss_s1  <= sample.dosage_missing && sample.zero_missing
				&& sample.one_missing && sample.two_missing;
			any_miss_s1  <= sample.dosage_missing || sample.zero_missing
				|| sample.one_missing || sample.two_missing;
			final_s1     <= sample.final_sample;
			e1_s1        <= e1_abs;
			e2_s1        <= e2_abs;
		end
	end

	// classification against the record state
	always_comb begin
		cnt_w    = LIM_W'(cfg.sample_count);
		max_w    = LIM_W'(MAX_SAMPLES);
		limit    = (cnt_w < max_w) ? cnt_w : max_w;
		idx_w    = LIM_W'(idx_q);
		too_many = idx_w >= limit;
		mismatch = too_many || ((idx_w + LIM_W'(1)) != cnt_w);

		prim    = PRIM_SKIP;
		stat    = STAT_OK;
		n_extra = 2'd0;
		if (!failed_q) begin
			if (too_many) begin
				prim = PRIM_ERROR;
				stat = STAT_COUNT;
			end else if (all_miss_s1) begin
				prim = PRIM_MISSING;
			end else if (any_miss_s1) begin
				prim = PRIM_ERROR;
				stat = STAT_PART_MISSING;
			end else if (range_bad_s1) begin
				prim = PRIM_ERROR;
				stat = STAT_RANGE;
			end else if (e1_s1 > MAG_W'(cfg.check_tol) || e2_s1 > MAG_W'(cfg.check_tol)) begin
				prim = PRIM_ERROR;
				stat = STAT_INCONSISTENT;
			end else begin
				prim = PRIM_VALUE;
				if (e1_s1 > MAG_W'(cfg.write_tol) || e2_s1 > MAG_W'(cfg.write_tol)) begin
					n_extra = 2'd3;
				end else if (p0_s1 != '0 && p2_s1 != '0) begin
					n_extra = 2'd1;
				end
			end
		end

		failed_next = failed_q || (prim == PRIM_ERROR);
		idx_next    = too_many ? idx_q : idx_q + 1'b1;
		extra_next  = extra_q + EXTRA_W'(n_extra);
		total       = (EXTRA_W + 1)'(idx_next) + (EXTRA_W + 1)'(extra_next);
		has_job     = (prim != PRIM_SKIP) || final_s1;

		push_job.prim          = prim;
		push_job.status        = stat;
		push_job.n_extra       = n_extra;
		push_job.pos           = idx_q;
		push_job.extra_base    = extra_q;
		push_job.d             = d_s1;
		push_job.p0            = p0_s1;
		push_job.p1            = p1_s1;
		push_job.p2            = p2_s1;
		push_job.report        = final_s1;
		push_job.report_status = mismatch ? STAT_COUNT : STAT_OK;
		push_job.bytes         = (mismatch || failed_next) ? '0 : BYTES_W'({total, 1'b0});
	end

	assign push = adv && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			extra_q  <= '0;
			failed_q <= 1'b0;
		end else if (adv) begin
			if (final_s1) begin
				idx_q    <= '0;
				extra_q  <= '0;
				failed_q <= 1'b0;
			end else begin
				idx_q    <= idx_next;
				extra_q  <= extra_next;
				failed_q <= failed_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gce_queue.sv =====
// ----------------------------------------------------------------------------
// gce_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module gce_queue import gce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gce_back.sv =====
// ----------------------------------------------------------------------------
// gce_back
// Walks the head job one result per cycle unless the result channel stalls,
// quantizes through a shared multiplier, drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gce_back import gce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  job_t               head,
	output logic               pop,
	input  logic [SCALE_W-1:0] scale,
	gce_result_if.source       result
);

	logic       prim_done_q;
	logic [1:0] ext_idx_q;

	logic       en, issue, do_prim, do_ext, last;

	// issued step
	logic                valid_s1;
	logic [VAL_W-1:0]    val_s1;
	logic [WORD_W-1:0]   word_s1;
	region_t             region_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [BYTES_W-1:0]  bytes_s1;
	status_t             status_s1;
	logic                end_s1;

	// product
	logic                valid_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [WORD_W-1:0]   word_s2;
	region_t             region_s2;
	logic [POS_W-1:0]    pos_s2;
	logic [BYTES_W-1:0]  bytes_s2;
	status_t             status_s2;
	logic                end_s2;

	logic [VAL_W-1:0]    val_n;
	logic [WORD_W-1:0]   word_n;
	region_t             region_n;
	logic [POS_W-1:0]    pos_n;
	logic [BYTES_W-1:0]  bytes_n;
	status_t             status_n;

	logic [PROD_W:0]                 rounded;
	logic [PROD_W-FRACTION_BITS:0]   q_full;
	logic [WORD_W-1:0]               q_sat;

	assign en    = !result.valid || result.ready;
	assign issue = en && head_valid;
	assign pop   = issue && last;

	// step selection and descriptor of the step
	always_comb begin
		do_prim = (head.prim != PRIM_SKIP) && !prim_done_q;
		do_ext  = !do_prim && (ext_idx_q < head.n_extra);

		val_n    = '0;
		word_n   = WORD_ZERO;
		region_n = REGION_PRIMARY;
		pos_n    = POS_W'(head.pos);
		bytes_n  = '0;
		status_n = STAT_OK;
		last     = 1'b1;

		if (do_prim) begin
			last = (head.n_extra == 2'd0) && !head.report;
			case (head.prim)
				PRIM_MISSING: word_n = WORD_ALL_MISSING;
				PRIM_ERROR:   status_n = head.status;
				PRIM_VALUE: begin
					val_n  = head.d;
					word_n = (head.n_extra != 2'd0) ? WORD_EXTRA_FLAG : WORD_ZERO;
				end
				default: ;
			endcase
		end else if (do_ext) begin
			last     = ((ext_idx_q + 2'd1) == head.n_extra) && !head.report;
			region_n = REGION_EXTRA;
			pos_n    = POS_W'(head.extra_base + EXTRA_W'(ext_idx_q));
			case (ext_idx_q)
				2'd0: begin
					val_n  = head.p1;
					word_n = (head.n_extra == 2'd3) ? WORD_EXTRA_FLAG : WORD_ZERO;
				end
				2'd1:    val_n = head.p0;
				default: val_n = head.p2;
			endcase
		end else begin
			region_n = REGION_LENGTH;
			pos_n    = '0;
			bytes_n  = head.bytes;
			status_n = head.report_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_done_q <= 1'b0;
			ext_idx_q   <= '0;
		end else if (issue) begin
			if (last) begin
				prim_done_q <= 1'b0;
				ext_idx_q   <= '0;
			end else if (do_prim) begin
				prim_done_q <= 1'b1;
			end else begin
				ext_idx_q <= ext_idx_q + 2'd1;
			end
		end
	end

	// round to nearest and saturate
	always_comb begin
		rounded = {1'b0, prod_s2} + ROUND_ADD;
		q_full  = rounded[PROD_W:FRACTION_BITS];
		q_sat   = (q_full > (PROD_W - FRACTION_BITS + 1)'(WORD_MAX))
			? WORD_MAX : q_full[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result.valid <= 1'b0;
		end else if (en) begin
			valid_s1     <= issue;
			valid_s2     <= valid_s1;
			result.valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1    <= val_n;
			word_s1   <= word_n;
			region_s1 <= region_n;
			pos_s1    <= pos_n;
			bytes_s1  <= bytes_n;
			status_s1 <= status_n;
			end_s1    <= last;

			prod_s2   <= val_s1 * scale;
			word_s2   <= word_s1;
			region_s2 <= region_s1;
			pos_s2    <= pos_s1;
			bytes_s2  <= bytes_s1;
			status_s2 <= status_s1;
			end_s2    <= end_s1;

			result.word         <= q_sat | word_s2;
			result.region       <= region_s2;
			result.position     <= pos_s2;
			result.record_bytes <= bytes_s2;
			result.status       <= status_s2;
			result.run_end      <= end_s2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/genotype_compact_encoder.sv =====
// ----------------------------------------------------------------------------
// genotype_compact_encoder
// Encodes dosage samples of a record into 16-bit words with optional extra
// probability words and a closing byte-length report.
// ----------------------------------------------------------------------------
// A sample item enters a front that checks missing flags, range and the two
// consistency errors and keeps the record state; it can take a new item
// every cycle until its four-entry job queue is full. The back walks the job
// at the queue head and makes one result item per cycle unless the result
// channel stalls, through a single 30x16 multiplier, so a sample takes one
// back step per result: a primary word, one or three extra words and, on a
// record's last sample, the length report. Samples of a failed record that
// cause no result pass the front and never reach the back. A sample passes
// the front register, the job queue and the back's issue, product and result
// registers. The result channel is registered; configuration writes are
// always ready and apply at once, so write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module genotype_compact_encoder import gce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	gce_sample_if.sink   sample,
	gce_result_if.source result,
	gce_cfg_if.sink      cfg
);

	// configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [TOL_W-1:0]   check_tol_q;
	logic [TOL_W-1:0]   write_tol_q;
	logic [COUNT_W-1:0] sample_count_q;
	cfg_t               cfg_regs;

	// front to queue
	logic push, full;
	job_t push_job;

	// queue to back
	logic head_valid, pop;
	job_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q        <= SCALE_RST;
			check_tol_q    <= CHECK_TOL_RST;
			write_tol_q    <= WRITE_TOL_RST;
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SCALE:        scale_q        <= cfg.data[SCALE_W-1:0];
				REG_CHECK_TOL:    check_tol_q    <= cfg.data[TOL_W-1:0];
				REG_WRITE_TOL:    write_tol_q    <= cfg.data[TOL_W-1:0];
				REG_SAMPLE_COUNT: sample_count_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_regs.scale        = scale_q;
		cfg_regs.check_tol    = check_tol_q;
		cfg_regs.write_tol    = write_tol_q;
		cfg_regs.sample_count = sample_count_q;
	end

	// classify samples, keep sample index, extra count and failure flag
	gce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.cfg      (cfg_regs),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	// decouples front and back so each side stalls on its own
	gce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// one result per cycle unless stalled, quantized by the shared multiplier
	gce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.scale      (scale_q),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== tb/genotype_compact_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// genotype_compact_encoder_tb
// Self-checking bench for the genotype compact encoder. A table of directed
// samples runs at reset settings, then random records run under several
// register settings with random gaps on both channels. Every result item is
// compared field by field against typed words or an in-bench encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module genotype_compact_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gce_pkg::*;

	// run control
	localparam int CYCLE_LIMIT   = 250000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 90;
	localparam int N_DIRECTED    = 23;

	// fixed point values used by the directed table
	localparam longint      UNIT       = longint'(1) << FRACTION_BITS;
	localparam logic [31:0] FX_ONE     = 32'h1000_0000;
	localparam logic [31:0] FX_TWO     = 32'h2000_0000;
	localparam logic [31:0] FX_HALF    = 32'h0800_0000;
	localparam logic [31:0] FX_QUARTER = 32'h0400_0000;
	localparam logic [31:0] FX_TIE     = 32'h0080_0000;

	// missing flag masks: dosage, zero, one, two
	localparam logic [3:0] MISS_NONE   = 4'b0000;
	localparam logic [3:0] MISS_ALL    = 4'b1111;
	localparam logic [3:0] MISS_DOSAGE = 4'b1000;
	localparam logic [3:0] MISS_PROBS  = 4'b0111;

	typedef struct packed {
		logic signed [DATA_W-1:0] dosage;
		logic signed [DATA_W-1:0] prob_zero;
		logic signed [DATA_W-1:0] prob_one;
		logic signed [DATA_W-1:0] prob_two;
		logic                     dosage_missing;
		logic                     zero_missing;
		logic                     one_missing;
		logic                     two_missing;
		logic                     final_sample;
	} sample_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		region_t            region;
		logic [POS_W-1:0]   position;
		logic [BYTES_W-1:0] record_bytes;
		status_t            status;
		logic               run_end;
	} coded_word_t;

	// directed row: a sample and, where obvious, its results typed in
	typedef struct packed {
		sample_t     smp;
		logic [1:0]  n_typed;
		coded_word_t first;
		coded_word_t second;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gce_sample_if sample_bus();
	gce_result_if result_bus();
	gce_cfg_if    reg_bus();

	genotype_compact_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg    (reg_bus)
	);

	// register shadow, same reset values as the block
	logic [SCALE_W-1:0] cfg_scale = SCALE_RST;
	logic [TOL_W-1:0]   cfg_check = CHECK_TOL_RST;
	logic [TOL_W-1:0]   cfg_write = WRITE_TOL_RST;
	logic [COUNT_W-1:0] cfg_count = SAMPLE_COUNT_RST;

	// record state of the in-bench encoder
	int unsigned rec_index  = 0;
	int unsigned rec_extras = 0;
	logic        rec_failed = 1'b0;

	coded_word_t pending_words[$];
	int          mismatches     = 0;
	int          offered        = 0;
	int          taken          = 0;
	logic        long_hold_req  = 1'b0;
	logic        long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic sample_t sample_of(input logic [31:0] d, p0, p1, p2,
			input logic [3:0] miss, input logic fin);
		sample_t s;
		s.dosage = d;
		s.prob_zero = p0;
		s.prob_one = p1;
		s.prob_two = p2;
		{s.dosage_missing, s.zero_missing, s.one_missing, s.two_missing} = miss;
		s.final_sample = fin;
		return s;
	endfunction

	function automatic coded_word_t word_of(input logic [WORD_W-1:0] w, input region_t r,
			input int unsigned pos, input int unsigned bytes, input status_t st,
			input logic last);
		coded_word_t c;
		c.word = w;
		c.region = r;
		c.position = POS_W'(pos);
		c.record_bytes = BYTES_W'(bytes);
		c.status = st;
		c.run_end = last;
		return c;
	endfunction

	// value times scale, round half down, saturate
	function automatic logic [WORD_W-1:0] quantize(input longint x);
		longint unsigned q;
		if (x <= 0)
			return WORD_ZERO;
		q = (longint'(x) * longint'(cfg_scale) + ((longint'(1) << (FRACTION_BITS - 1)) - 1))
			>> FRACTION_BITS;
		return (q > longint'(WORD_MAX)) ? WORD_MAX : q[WORD_W-1:0];
	endfunction

	// results one sample causes, advancing the record state
	task automatic encode_sample(input sample_t s, output coded_word_t res[$]);
		longint      d, p0, p1, p2, e1, e2;
		int unsigned nmiss, lim;
		logic        too_many, bad_count;
		int unsigned pos;
		status_t     err;
		logic [WORD_W-1:0] w;
		res = {};
		d = $signed(s.dosage);
		p0 = $signed(s.prob_zero);
		p1 = $signed(s.prob_one);
		p2 = $signed(s.prob_two);
		nmiss = $countones({s.dosage_missing, s.zero_missing, s.one_missing, s.two_missing});
		lim = (cfg_count < MAX_SAMPLES) ? cfg_count : MAX_SAMPLES;
		too_many = rec_index >= lim;
		bad_count = too_many || (rec_index + 1 != cfg_count);
		pos = rec_index;
		err = STAT_OK;
		if (!rec_failed) begin
			if (too_many)
				err = STAT_COUNT;
			else if (nmiss == 4)
				res.push_back(word_of(WORD_ALL_MISSING, REGION_PRIMARY, pos, 0, STAT_OK, 1'b0));
			else if (nmiss != 0)
				err = STAT_PART_MISSING;
			else if (d < 0 || d > 2 * UNIT || p0 < 0 || p0 > UNIT || p1 < 0 || p1 > UNIT ||
					p2 < 0 || p2 > UNIT)
				err = STAT_RANGE;
			else begin
				e1 = UNIT - p0 - p1 - p2;
				e2 = d - p1 - 2 * p2;
				if (e1 < 0) e1 = -e1;
				if (e2 < 0) e2 = -e2;
				if (e1 > longint'(cfg_check) || e2 > longint'(cfg_check))
					err = STAT_INCONSISTENT;
				else begin
					w = quantize(d);
					if (e1 > longint'(cfg_write) || e2 > longint'(cfg_write)) begin
						// all three probabilities follow, p1 flagged
						res.push_back(word_of(w | WORD_EXTRA_FLAG, REGION_PRIMARY, pos, 0,
							STAT_OK, 1'b0));
						res.push_back(word_of(quantize(p1) | WORD_EXTRA_FLAG, REGION_EXTRA,
							rec_extras, 0, STAT_OK, 1'b0));
						res.push_back(word_of(quantize(p0), REGION_EXTRA, rec_extras + 1, 0,
							STAT_OK, 1'b0));
						res.push_back(word_of(quantize(p2), REGION_EXTRA, rec_extras + 2, 0,
							STAT_OK, 1'b0));
						rec_extras += 3;
					end else if (p0 != 0 && p2 != 0) begin
						res.push_back(word_of(w | WORD_EXTRA_FLAG, REGION_PRIMARY, pos, 0,
							STAT_OK, 1'b0));
						res.push_back(word_of(quantize(p1), REGION_EXTRA, rec_extras, 0,
							STAT_OK, 1'b0));
						rec_extras += 1;
					end else
						res.push_back(word_of(w, REGION_PRIMARY, pos, 0, STAT_OK, 1'b0));
				end
			end
			if (err != STAT_OK) begin
				res.push_back(word_of(WORD_ZERO, REGION_PRIMARY, pos, 0, err, 1'b0));
				rec_failed = 1'b1;
			end
		end
		if (!too_many)
			rec_index++;
		if (s.final_sample) begin
			res.push_back(word_of(WORD_ZERO, REGION_LENGTH, 0,
				(bad_count || rec_failed) ? 0 : 2 * (rec_index + rec_extras),
				bad_count ? STAT_COUNT : STAT_OK, 1'b0));
			rec_index = 0;
			rec_extras = 0;
			rec_failed = 1'b0;
		end
		if (res.size() != 0)
			res[res.size() - 1].run_end = 1'b1;
	endtask

	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	// one sample item: random gap, handshake, then its expected results queued
	task automatic send_sample(input sample_t s, input logic [1:0] n_typed,
			input coded_word_t first, input coded_word_t second);
		int gap;
		coded_word_t words[$];
		// every 40 items a stretch of back to back offers
		gap = (offered % 40 < 8) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.dosage <= s.dosage;
		sample_bus.prob_zero <= s.prob_zero;
		sample_bus.prob_one <= s.prob_one;
		sample_bus.prob_two <= s.prob_two;
		sample_bus.dosage_missing <= s.dosage_missing;
		sample_bus.zero_missing <= s.zero_missing;
		sample_bus.one_missing <= s.one_missing;
		sample_bus.two_missing <= s.two_missing;
		sample_bus.final_sample <= s.final_sample;
		sample_bus.valid <= 1'b1;
		do @(posedge clk); while (!sample_bus.ready);
		// state always advances; typed rows override the computed words
		encode_sample(s, words);
		if (n_typed == 0)
			foreach (words[i]) pending_words.push_back(words[i]);
		else begin
			pending_words.push_back(first);
			if (n_typed == 2)
				pending_words.push_back(second);
		end
		offered++;
	endtask

	// sender pauses until every expected result is back, plus pipeline slack
	task automatic settle();
		sample_bus.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, valid held by the caller
	task automatic put_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		reg_bus.index <= idx;
		reg_bus.data <= value;
		do @(posedge clk); while (!reg_bus.ready);
		case (idx)
			REG_SCALE:        cfg_scale = value[SCALE_W-1:0];
			REG_CHECK_TOL:    cfg_check = value[TOL_W-1:0];
			REG_WRITE_TOL:    cfg_write = value[TOL_W-1:0];
			REG_SAMPLE_COUNT: cfg_count = value[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] v_scale, v_check, v_write,
			v_count);
		reg_bus.valid <= 1'b1;
		put_reg(REG_SCALE, v_scale);
		put_reg(REG_CHECK_TOL, v_check);
		put_reg(REG_WRITE_TOL, v_write);
		put_reg(REG_SAMPLE_COUNT, v_count);
		reg_bus.valid <= 1'b0;
	endtask

	// mostly consistent samples with a slip sized against the tolerances
	task automatic draw_sample(input logic last, output sample_t s);
		longint p0, p1, p2, d, slip;
		logic [3:0] miss;
		s = '0;
		if ($urandom_range(0, 99) < 84) begin
			p1 = $urandom_range(0, 32'(UNIT));
			p2 = $urandom_range(0, 32'(UNIT - p1));
			p0 = UNIT - p1 - p2;
			case ($urandom_range(0, 4))
				0: begin p1 += p0; p0 = 0; end
				1: begin p1 += p2; p2 = 0; end
				default: ;
			endcase
			d = p1 + 2 * p2;
			// boundaries of both tolerances, equal never exceeds
			case ($urandom_range(0, 9))
				0, 1, 2: slip = 0;
				3: slip = $urandom_range(0, cfg_write);
				4: slip = cfg_write;
				5: slip = longint'(cfg_write) + 1;
				6: slip = cfg_check;
				7: slip = longint'(cfg_check) + 1;
				default: slip = $urandom_range(0, cfg_check);
			endcase
			if ($urandom_range(0, 1)) slip = -slip;
			if ($urandom_range(0, 1)) d += slip;
			else p0 += slip;
			s = sample_of(d[31:0], p0[31:0], p1[31:0], p2[31:0], MISS_NONE, last);
		end else begin
			// noise: raw words, near-range values, odd flags, stray record ends
			case ($urandom_range(0, 2))
				0: miss = MISS_NONE;
				1: miss = MISS_ALL;
				default: miss = 4'($urandom_range(0, 15));
			endcase
			if ($urandom_range(0, 1))
				s = sample_of($urandom(), $urandom(), $urandom(), $urandom(), miss, 1'b0);
			else
				s = sample_of($urandom_range(0, 32'(2 * UNIT + 2)),
					$urandom_range(0, 32'(UNIT + 1)), $urandom_range(0, 32'(UNIT + 1)),
					$urandom_range(0, 32'(UNIT + 1)), miss, 1'b0);
			s.final_sample = last | ($urandom_range(0, 9) == 0);
		end
	endtask

	// whole records, mostly of the configured length if it is one to eight
	task automatic run_records(input int n_items);
		int sent, len;
		sample_t s;
		sent = 0;
		while (sent < n_items) begin
			if (cfg_count >= 1 && cfg_count <= 8)
				len = ($urandom_range(0, 9) < 8) ? int'(cfg_count) :
					$urandom_range(1, int'(cfg_count) + 2);
			else
				len = $urandom_range(1, 4);
			for (int k = 0; k < len; k++) begin
				draw_sample(k == len - 1, s);
				send_sample(s, 2'd0, '0, '0);
				sent++;
			end
		end
	endtask

	// result side: random ready gaps, one long hold-off, field by field check
	initial begin : word_sink
		int gap;
		coded_word_t want;
		result_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		result_bus.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				if (pending_words.size() == 0)
					flag_error($sformatf("unexpected item: word %h region %0d pos %0d",
						result_bus.word, result_bus.region, result_bus.position));
				else begin
					want = pending_words.pop_front();
					if (result_bus.word !== want.word || result_bus.region !== want.region ||
							result_bus.position !== want.position ||
							result_bus.record_bytes !== want.record_bytes ||
							result_bus.status !== want.status ||
							result_bus.run_end !== want.run_end)
						flag_error($sformatf(
							"item %0d: got %h/%0d/%0d/%0d/%0d/%b want %h/%0d/%0d/%0d/%0d/%b",
							taken, result_bus.word, result_bus.region, result_bus.position,
							result_bus.record_bytes, result_bus.status, result_bus.run_end,
							want.word, want.region, want.position, want.record_bytes,
							want.status, want.run_end));
				end
				taken++;
				gap = (taken % 50 < 10) ? 0 : $urandom_range(0, 6);
				// long stall so the job queue fills and input backs up
				if (long_hold_req && !long_hold_done) begin
					gap = LONG_HOLD;
					long_hold_done = 1'b1;
				end
				if (gap > 0) begin
					result_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
					result_bus.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("genotype_compact_encoder: mismatch");
		$finish;
	end

	initial begin : stimulus
		dir_row_t directed_rows [N_DIRECTED];
		arst_n <= 1'b0;
		sample_bus.valid <= 1'b0;
		sample_bus.dosage <= '0;
		sample_bus.prob_zero <= '0;
		sample_bus.prob_one <= '0;
		sample_bus.prob_two <= '0;
		sample_bus.dosage_missing <= 1'b0;
		sample_bus.zero_missing <= 1'b0;
		sample_bus.one_missing <= 1'b0;
		sample_bus.two_missing <= 1'b0;
		sample_bus.final_sample <= 1'b0;
		reg_bus.valid <= 1'b0;
		reg_bus.index <= REG_SCALE;
		reg_bus.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one sample per record but for the last two records
		directed_rows = '{
			// all missing, then a clean record length
			'{sample_of(0, 0, 0, 0, MISS_ALL, 1), 2'd2,
				word_of(WORD_ALL_MISSING, REGION_PRIMARY, 0, 0, STAT_OK, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 2, STAT_OK, 1)},
			// partly missing
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_DOSAGE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_PART_MISSING, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			'{sample_of(0, 0, 0, 0, MISS_PROBS, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_PART_MISSING, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			// out of range on each side
			'{sample_of(32'hFFFF_FFFF, FX_ONE, 0, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_RANGE, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			'{sample_of(FX_TWO + 1, 0, 0, FX_ONE, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_RANGE, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			'{sample_of(0, 32'h8000_0000, 0, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_RANGE, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			'{sample_of(FX_ONE, 0, 0, 32'h7FFF_FFFF, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_RANGE, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			'{sample_of(FX_ONE, 0, FX_ONE + 1, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_RANGE, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			// probabilities sum to two
			'{sample_of(0, FX_ONE, FX_ONE, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_INCONSISTENT, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			// dosage extremes, plain words
			'{sample_of(0, FX_ONE, 0, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_OK, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 2, STAT_OK, 1)},
			'{sample_of(FX_TWO, 0, 0, FX_ONE, MISS_NONE, 1), 2'd2,
				word_of(16'd20000, REGION_PRIMARY, 0, 0, STAT_OK, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 2, STAT_OK, 1)},
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_NONE, 1), 2'd0, '0, '0},
			// both outer probabilities set: one extra word
			'{sample_of(FX_ONE, FX_QUARTER, FX_HALF, FX_QUARTER, MISS_NONE, 1), 2'd0, '0, '0},
			// above write tolerance: three extra words
			'{sample_of(FX_HALF + 1000, FX_HALF, FX_HALF, 0, MISS_NONE, 1), 2'd0, '0, '0},
			// exact rounding tie goes down
			'{sample_of(FX_TIE, FX_ONE - FX_TIE, FX_TIE, 0, MISS_NONE, 1), 2'd0, '0, '0},
			// error equal to the check limit still passes
			'{sample_of(FX_HALF + CHECK_TOL_RST, FX_HALF, FX_HALF, 0, MISS_NONE, 1),
				2'd0, '0, '0},
			'{sample_of(FX_HALF + CHECK_TOL_RST + 1, FX_HALF, FX_HALF, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_INCONSISTENT, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_OK, 1)},
			// error equal to the write limit stays plain
			'{sample_of(FX_HALF + WRITE_TOL_RST, FX_HALF, FX_HALF, 0, MISS_NONE, 1),
				2'd0, '0, '0},
			// record one longer than the count
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_NONE, 0), 2'd0, '0, '0},
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_NONE, 1), 2'd2,
				word_of(WORD_ZERO, REGION_PRIMARY, 1, 0, STAT_COUNT, 0),
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_COUNT, 1)},
			// failed record goes quiet until its length report
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_DOSAGE, 0), 2'd1,
				word_of(WORD_ZERO, REGION_PRIMARY, 0, 0, STAT_PART_MISSING, 1), '0},
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_NONE, 0), 2'd0, '0, '0},
			'{sample_of(FX_ONE, 0, FX_ONE, 0, MISS_NONE, 1), 2'd1,
				word_of(WORD_ZERO, REGION_LENGTH, 0, 0, STAT_COUNT, 1), '0}
		};
		foreach (directed_rows[i])
			send_sample(directed_rows[i].smp, directed_rows[i].n_typed,
				directed_rows[i].first, directed_rows[i].second);
		settle();

		// random records under a spread of settings, idle between them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_regs(SCALE_RST, CHECK_TOL_RST, WRITE_TOL_RST, 3);
				// max scale and check limit, zero write limit, saturates with flag bit
				1: write_regs(16'hFFFF, 29'h1FFF_FFFF, 0, 1);
				// scale zero, only exact sums pass
				2: write_regs(0, 0, 0, 4);
				3: write_regs(1, UNIT, UNIT, 2);
				// random settings, junk above the register widths
				4: write_regs({13'($urandom()), 16'($urandom())},
					$urandom_range(0, 32'(UNIT)), $urandom_range(0, 32'(UNIT >> 6)),
					{8'($urandom()), 21'($urandom_range(1, 6))});
				// count zero: every sample overflows
				5: write_regs(12345, CHECK_TOL_RST, WRITE_TOL_RST, 0);
				6: write_regs(SCALE_RST, CHECK_TOL_RST, WRITE_TOL_RST, MAX_SAMPLES);
				default: write_regs(SCALE_RST, CHECK_TOL_RST, WRITE_TOL_RST, 21'h1F_FFFF);
			endcase
			if (ph == 2)
				long_hold_req = 1'b1;
			run_records(ph < 5 ? 55 : 22);
			settle();
		end

		if (mismatches == 0) begin
			$display("genotype_compact_encoder: match");
		end else begin
			$display("genotype_compact_encoder: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/gce_pkg.sv
rtl/core/gce_sample_if.sv
rtl/core/gce_result_if.sv
rtl/core/gce_cfg_if.sv
rtl/core/gce_front.sv
rtl/core/gce_queue.sv
rtl/core/gce_back.sv
rtl/core/genotype_compact_encoder.sv
tb/genotype_compact_encoder_tb.sv
